// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the span generator RTL.
// Included by modules that carry concurrent checks; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCSG_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fcsg assertion failed");
`define FCSG_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("fcsg forbidden condition seen");
`else
`define FCSG_ASSERT(label, clk, rst_n, prop)
`define FCSG_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hdl/fcsg_pkg.sv -----
// Shared types, constants and tables of the filled circle span generator.
// No dependencies.
package fcsg_pkg;

	localparam int COORD_W  = 16;
	localparam int COLOR_W  = 16;
	localparam int RADIUS_W = 5;
	localparam int SCREEN_W = 12;
	localparam int LEN_W    = 6;
	localparam int IDX_W    = 4;
	localparam int SQ_W     = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [RADIUS_W-1:0] MAX_RADIUS = 5'd20;

	localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 12'd800;
	localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 12'd480;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] row;
		logic [LEN_W-1:0]   len;
		logic [COLOR_W-1:0] color;
		logic               last;
	} span_cmd_t;

	// r*707/1000 + 1, radius already saturated
	function automatic logic [IDX_W-1:0] imax_of(input logic [RADIUS_W-1:0] r);
		logic [IDX_W-1:0] v;
		unique case (r)
			5'd0, 5'd1: v = 4'd1;
			5'd2:       v = 4'd2;
			5'd3, 5'd4: v = 4'd3;
			5'd5:       v = 4'd4;
			5'd6, 5'd7: v = 4'd5;
			5'd8:       v = 4'd6;
			5'd9:       v = 4'd7;
			5'd10, 5'd11: v = 4'd8;
			5'd12:      v = 4'd9;
			5'd13, 5'd14: v = 4'd10;
			5'd15:      v = 4'd11;
			5'd16:      v = 4'd12;
			5'd17, 5'd18: v = 4'd13;
			5'd19:      v = 4'd14;
			5'd20:      v = 4'd15;
			default:    v = 4'd15;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/fcsg_ifs.sv -----
// Valid/ready channel interfaces: circle requests in, spans out.
// Depends on fcsg_pkg for field widths.
interface fcsg_circle_if;
	logic                            valid;
	logic                            ready;
	logic [fcsg_pkg::COORD_W-1:0]    center_x;
	logic [fcsg_pkg::COORD_W-1:0]    center_y;
	logic [fcsg_pkg::RADIUS_W-1:0]   radius;
	logic [fcsg_pkg::COLOR_W-1:0]    fill_color;
	modport source (output valid, center_x, center_y, radius, fill_color, input ready);
	modport sink (input valid, center_x, center_y, radius, fill_color, output ready);
endinterface

interface fcsg_span_if;
	logic                         valid;
	logic                         ready;
	logic [fcsg_pkg::COORD_W-1:0] span_x_start;
	logic [fcsg_pkg::COORD_W-1:0] span_x_end;
	logic [fcsg_pkg::COORD_W-1:0] span_row;
	logic [fcsg_pkg::COLOR_W-1:0] span_color;
	logic                         last_span;
	modport source (output valid, span_x_start, span_x_end, span_row, span_color,
		last_span, input ready);
	modport sink (input valid, span_x_start, span_x_end, span_row, span_color,
		last_span, output ready);
endinterface

// ----- hdl/fcsg_fifo.sv -----
// Short span command queue between the span sequencer and the clip stage.
// Depends on fcsg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fcsg_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fcsg_pkg::span_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output fcsg_pkg::span_cmd_t head,
	output logic                empty
);
	fcsg_pkg::span_cmd_t entry_q [fcsg_pkg::QUEUE_DEPTH];
	logic [fcsg_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [fcsg_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [fcsg_pkg::QUEUE_AW:0]   count_q;

	assign full  = (count_q == (fcsg_pkg::QUEUE_AW+1)'(fcsg_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`FCSG_NEVER(a_no_push_full, clk, arst_n, push && full && !pop)
	`FCSG_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)
	`FCSG_ASSERT(a_count_bound, clk, arst_n,
		count_q <= (fcsg_pkg::QUEUE_AW+1)'(fcsg_pkg::QUEUE_DEPTH))

endmodule

// ----- hdl/fcsg_front.sv -----
// Front end: takes circle transfers and sequences the raw spans of each circle.
// Depends on fcsg_pkg, fcsg_ifs and assert_macros.svh.
`include "assert_macros.svh"
module fcsg_front (
	input  logic                clk,
	input  logic                arst_n,
	fcsg_circle_if.sink         circle,
	output logic                push,
	output fcsg_pkg::span_cmd_t push_cmd,
	input  logic                full
);
	typedef enum logic [1:0] {S_IDLE, S_CENTER, S_LOOP, S_FLUSH} state_t;
	typedef enum logic [1:0] {PH_TOP_POS, PH_TOP_NEG, PH_ROW_POS, PH_ROW_NEG} phase_t;

	state_t                          state_q;
	phase_t                          phase_q;
	logic [fcsg_pkg::COORD_W-1:0]    cx_q;
	logic [fcsg_pkg::COORD_W-1:0]    cy_q;
	logic [fcsg_pkg::RADIUS_W-1:0]   r_q;
	logic [fcsg_pkg::COLOR_W-1:0]    color_q;
	logic [fcsg_pkg::IDX_W-1:0]      imax_q;
	logic [fcsg_pkg::SQ_W-1:0]       sqmax_q;
	logic [fcsg_pkg::RADIUS_W-1:0]   x_q;
	logic [fcsg_pkg::IDX_W-1:0]      i_q;
	logic                            cond_q;
	fcsg_pkg::span_cmd_t             pend_q;
	logic                            pend_v_q;

	logic [fcsg_pkg::RADIUS_W-1:0]   r_sat;
	logic [7:0]                      i_sq;
	logic [9:0]                      x_sq;
	logic [9:0]                      sq_sum;
	logic                            cond_now;
	logic                            x_gt;
	logic [fcsg_pkg::IDX_W-1:0]      i_m1;
	logic                            cand_en;
	fcsg_pkg::span_cmd_t             cand;
	logic                            adv;
	logic                            cand_ok;

	assign r_sat = (circle.radius > fcsg_pkg::MAX_RADIUS) ? fcsg_pkg::MAX_RADIUS
		: circle.radius;
	assign circle.ready = (state_q == S_IDLE);

	assign i_sq     = {4'b0, i_q} * {4'b0, i_q};
	assign x_sq     = {5'b0, x_q} * {5'b0, x_q};
	assign sq_sum   = {2'b0, i_sq} + x_sq;
	assign cond_now = (sq_sum > {1'b0, sqmax_q});
	assign x_gt     = (x_q > {1'b0, imax_q});
	assign i_m1     = i_q - 1'b1;

	always_comb begin
		cand_en    = 1'b0;
		cand.sx    = cx_q - 16'(x_q);
		cand.row   = cy_q;
		cand.len   = {x_q, 1'b0};
		cand.color = color_q;
		cand.last  = 1'b0;
		if (state_q == S_CENTER) begin
			cand_en  = 1'b1;
			cand.sx  = cx_q - 16'(r_q);
			cand.row = cy_q;
			cand.len = {r_q, 1'b0};
		end else if (state_q == S_LOOP) begin
			unique case (phase_q)
				PH_TOP_POS: begin
					cand_en  = cond_now && x_gt;
					cand.sx  = cx_q - 16'(i_q) + 16'd1;
					cand.row = cy_q + 16'(x_q);
					cand.len = {1'b0, i_m1, 1'b0};
				end
				PH_TOP_NEG: begin
					cand_en  = cond_q && x_gt;
					cand.sx  = cx_q - 16'(i_q) + 16'd1;
					cand.row = cy_q - 16'(x_q);
					cand.len = {1'b0, i_m1, 1'b0};
				end
				PH_ROW_POS: begin
					cand_en  = 1'b1;
					cand.row = cy_q + 16'(i_q);
				end
				PH_ROW_NEG: begin
					cand_en  = 1'b1;
					cand.row = cy_q - 16'(i_q);
				end
				default: begin
					cand_en = 1'b0;
				end
			endcase
		end
	end

	assign adv     = !full && (state_q == S_CENTER || state_q == S_LOOP);
	assign cand_ok = adv && cand_en && (cand.len != '0);

	// a span is held back until the next one shows up, so the final one gets last set
	assign push = (cand_ok && pend_v_q) || (state_q == S_FLUSH && !full);
	always_comb begin
		push_cmd      = pend_q;
		push_cmd.last = (state_q == S_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_v_q <= 1'b0;
			phase_q  <= PH_TOP_POS;
			cx_q     <= '0;
			cy_q     <= '0;
			r_q      <= '0;
			color_q  <= '0;
			imax_q   <= '0;
			sqmax_q  <= '0;
			x_q      <= '0;
			i_q      <= '0;
			cond_q   <= 1'b0;
			pend_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (circle.valid) begin
						cx_q    <= circle.center_x;
						cy_q    <= circle.center_y;
						r_q     <= r_sat;
						color_q <= circle.fill_color;
						imax_q  <= fcsg_pkg::imax_of(r_sat);
						sqmax_q <= 9'({4'b0, r_sat} * {4'b0, r_sat}) + 9'(r_sat >> 1);
						if (r_sat != '0) begin
							state_q <= S_CENTER;
						end
					end
				end
				S_CENTER: begin
					if (adv) begin
						state_q <= S_LOOP;
						phase_q <= PH_TOP_POS;
						i_q     <= 4'd1;
						x_q     <= r_q;
					end
				end
				S_LOOP: begin
					if (adv) begin
						unique case (phase_q)
							PH_TOP_POS: begin
								cond_q  <= cond_now;
								phase_q <= PH_TOP_NEG;
							end
							PH_TOP_NEG: begin
								if (cond_q && x_q != '0) begin
									x_q <= x_q - 1'b1;
								end
								phase_q <= PH_ROW_POS;
							end
							PH_ROW_POS: begin
								phase_q <= PH_ROW_NEG;
							end
							PH_ROW_NEG: begin
								phase_q <= PH_TOP_POS;
								if (i_q == imax_q) begin
									state_q <= S_FLUSH;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end
							default: begin
								phase_q <= PH_TOP_POS;
							end
						endcase
					end
				end
				S_FLUSH: begin
					if (!full) begin
						state_q  <= S_IDLE;
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cand_ok) begin
				pend_q   <= cand;
				pend_v_q <= 1'b1;
			end
		end
	end

	`FCSG_ASSERT(a_flush_has_span, clk, arst_n, state_q == S_FLUSH |-> pend_v_q)
	`FCSG_ASSERT(a_x_bounded, clk, arst_n, state_q == S_LOOP |-> x_q <= r_q)
	`FCSG_ASSERT(a_i_bounded, clk, arst_n,
		state_q == S_LOOP |-> (i_q != '0 && i_q <= imax_q))

endmodule

// ----- hdl/fcsg_back.sv -----
// Back end: clips queued spans to the screen and holds them in the output register.
// Depends on fcsg_pkg and fcsg_ifs.
module fcsg_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fcsg_pkg::span_cmd_t            head,
	input  logic                           empty,
	output logic                           pop,
	input  logic [fcsg_pkg::SCREEN_W-1:0]  screen_width,
	input  logic [fcsg_pkg::SCREEN_W-1:0]  screen_height,
	fcsg_span_if.source                    span
);
	logic                         out_v_q;
	logic [fcsg_pkg::COORD_W-1:0] xs_q;
	logic [fcsg_pkg::COORD_W-1:0] xe_q;
	logic [fcsg_pkg::COORD_W-1:0] row_q;
	logic [fcsg_pkg::COLOR_W-1:0] color_q;
	logic                         last_q;

	logic [fcsg_pkg::COORD_W:0]   end_wide;
	logic [fcsg_pkg::COORD_W-1:0] sx_c;
	logic [fcsg_pkg::COORD_W-1:0] row_c;
	logic [fcsg_pkg::COORD_W-1:0] xe_c;

	assign pop = !empty && (!out_v_q || span.ready);

	always_comb begin
		end_wide = {1'b0, head.sx} + 17'(head.len) - 17'd1;
		sx_c = head.sx;
		if (end_wide >= {5'b0, screen_width}) begin
			sx_c = {4'b0, screen_width} - 16'(head.len) - 16'd1;
		end
		row_c = head.row;
		if (head.row >= {4'b0, screen_height}) begin
			row_c = {4'b0, screen_height} - 16'd1;
		end
		xe_c = sx_c + 16'(head.len) - 16'd1;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			xs_q    <= sx_c;
			xe_q    <= xe_c;
			row_q   <= row_c;
			color_q <= head.color;
			last_q  <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (span.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign span.valid        = out_v_q;
	assign span.span_x_start = xs_q;
	assign span.span_x_end   = xe_q;
	assign span.span_row     = row_q;
	assign span.span_color   = color_q;
	assign span.last_span    = last_q;

endmodule

// ----- hdl/filled_circle_span_generator_core.sv -----
// Top level of the filled circle span generator: config registers and the
// front end, span queue and clip stage. Depends on fcsg_pkg, fcsg_ifs and submodules.
//
// Usage:
//   circle: valid/ready sink; one transfer per circle (center_x, center_y,
//           radius, fill_color). Radius saturates at 20; radius 0 yields no span.
//   span:   valid/ready source; one transfer per nonempty span, last_span set
//           on the final span of each circle.
//   cfg:    cfg_we/cfg_index/cfg_wdata write screen_width (0) and screen_height (1);
//           write only while the block is idle.
// Sequencing: the sequencer emits the center row, then steps through the phases
//   top-pos, top-neg, row-pos and row-neg for each inner row index
//   (imax = r*707/1000+1) and ends in a flush state; the next circle is taken
//   once it is back in idle, and it pauses while the queue is full. A radius 0
//   circle leaves the sequencer in idle. The first span is held in the sequencer
//   until the next span or the flush, then goes through the queue and output register.
// Reset clears the queue and output valid and loads width 800, height 480.
// When the span receiver stalls, the 4-entry queue fills and the sequencer
// pauses; no span is lost.
module filled_circle_span_generator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	fcsg_circle_if.sink                     circle,
	fcsg_span_if.source                     span,
	input  logic                            cfg_we,
	input  logic [fcsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcsg_pkg::SCREEN_W-1:0]   cfg_wdata
);
	logic [fcsg_pkg::SCREEN_W-1:0] width_q;
	logic [fcsg_pkg::SCREEN_W-1:0] height_q;

	logic                push;
	fcsg_pkg::span_cmd_t push_cmd;
	logic                full;
	logic                pop;
	fcsg_pkg::span_cmd_t head;
	logic                empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fcsg_pkg::WIDTH_RESET;
			height_q <= fcsg_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (fcsg_pkg::reg_index_t'(cfg_index))
				fcsg_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				fcsg_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	fcsg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.circle   (circle),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	fcsg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	fcsg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.screen_width  (width_q),
		.screen_height (height_q),
		.span          (span)
	);

endmodule
